// ===== hw/rtl/clsr_pkg.sv =====
// Shared types and defaults for the call stack loop remover.
// Used by clsr_front, clsr_back and the top level; depends on nothing.
package clsr_pkg;

  localparam int unsigned DefMaxDepth = 64;
  localparam int unsigned DefMaxLinks = 8;
  localparam int unsigned AddrW       = 64;

  // How the front tags an item before it enters the queue
  typedef enum logic [1:0] {
    KIND_FIRST  = 2'd0,
    KIND_NORMAL = 2'd1,
    KIND_DEEP   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic             last;
    kind_e            kind;
  } item_t;

endpackage

// ===== hw/rtl/call_stack_loop_remover.sv =====
// Top level of the call stack loop remover.
// Depends on clsr_pkg, clsr_front, clsr_back (and clsr_ram below it).
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+---------------------------
//  input   | address_i[63:0], last_i                      | start_i high, busy_o low
//  result  | address_res_o[63:0], last_res_o, error_o     | res_valid_o, one cycle
//
// Flow: the front takes a beat whenever its two-entry queue has room. The
// back searches the node RAM for the address over the allocated nodes, then
// the current node's existing links in the link RAM, then does bookkeeping.
// After a final beat it walks the tables and emits results one at a time
// (node read, link read, emit), taking no new beat until the walk ends.
// Reset clears control state; RAM contents are not cleared, a node count and
// per-node link counts mark what is live. The receiver cannot stall; busy_o
// rises only when the queue is full.
module call_stack_loop_remover import clsr_pkg::*; #(
  parameter int unsigned MAX_DEPTH = DefMaxDepth,
  parameter int unsigned MAX_LINKS = DefMaxLinks
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [AddrW-1:0] address_i,
  input  logic             last_i,
  output logic             res_valid_o,
  output logic [AddrW-1:0] address_res_o,
  output logic             last_res_o,
  output logic             error_o
);

  // Queue head handed from the front to the back
  logic  head_valid;
  item_t head;
  logic  pop;

  // Accept and tag beats, hold them until the back is free
  clsr_front #(.MaxDepth(MAX_DEPTH)) u_front (
    .clk_i, .rst_ni, .start_i, .busy_o, .address_i, .last_i,
    .head_valid_o(head_valid), .head_o(head), .pop_i(pop)
  );

  // Build the tables, then walk and drive result beats
  clsr_back #(.MaxDepth(MAX_DEPTH), .MaxLinks(MAX_LINKS)) u_back (
    .clk_i, .rst_ni, .head_valid_i(head_valid), .head_i(head), .pop_o(pop),
    .res_valid_o, .address_res_o, .last_res_o, .error_o
  );

endmodule

// ===== hw/rtl/clsr_ram.sv =====
// Generic single write port RAM with registered read.
// Standalone; no package dependencies.
module clsr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/clsr_front.sv =====
// Front part: accepts address beats, tags them by position in the stack,
// and holds them in a two-entry queue. Depends on clsr_pkg.
module clsr_front import clsr_pkg::*; #(
  parameter int unsigned MaxDepth = DefMaxDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [AddrW-1:0] address_i,
  input  logic             last_i,
  output logic             head_valid_o,
  output item_t            head_o,
  input  logic             pop_i
);

  localparam int unsigned CntW = $clog2(MaxDepth + 1);

  item_t          q_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     fill_q;
  logic [CntW-1:0] cnt_q;
  logic           push;
  item_t          item;

  assign busy_o       = (fill_q == 2'd2);
  assign push         = start_i && !busy_o;
  assign head_valid_o = (fill_q != 2'd0);
  assign head_o       = q_q[rp_q];

  always_comb begin
    item.addr = address_i;
    item.last = last_i;
    if (cnt_q == '0) begin
      item.kind = KIND_FIRST;
    end else if (cnt_q >= CntW'(MaxDepth)) begin
      item.kind = KIND_DEEP;
    end else begin
      item.kind = KIND_NORMAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        q_q[wp_q] <= item;
        wp_q      <= ~wp_q;
        if (last_i) begin
          cnt_q <= '0;
        end else if (cnt_q != CntW'(MaxDepth)) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  ap_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3) else $error("queue fill out of range");
  ap_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o) else $error("pop from empty queue");
  ap_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxDepth)) else $error("depth count out of range");

endmodule

// ===== hw/rtl/clsr_back.sv =====
// Back part: builds the node and link tables for one stack, then walks
// them and emits the rebuilt stack. Depends on clsr_pkg and clsr_ram.
module clsr_back import clsr_pkg::*; #(
  parameter int unsigned MaxDepth = DefMaxDepth,
  parameter int unsigned MaxLinks = DefMaxLinks
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  item_t            head_i,
  output logic             pop_o,
  output logic             res_valid_o,
  output logic [AddrW-1:0] address_res_o,
  output logic             last_res_o,
  output logic             error_o
);

  localparam int unsigned NW  = $clog2(MaxDepth);
  localparam int unsigned CW  = $clog2(MaxDepth + 1);
  localparam int unsigned LW  = (MaxLinks > 1) ? $clog2(MaxLinks) : 1;
  localparam int unsigned LCW = $clog2(MaxLinks + 1);
  localparam int unsigned MW  = 2 * LCW;
  localparam int unsigned LD  = MaxDepth << LW;

  typedef enum logic [3:0] {
    S_IDLE, S_NSCAN, S_META, S_LSCAN, S_ADD, S_NEWN, S_FIN, S_OVF,
    S_WRD, S_WLK, S_WTG
  } state_e;

  state_e           state_q;
  logic [AddrW-1:0] addr_q;
  logic             last_q, ovf_q, found_q, ph_q;
  logic [NW-1:0]    cur_q, j_q, tgt_q, n_q;
  logic [CW-1:0]    ncnt_q, rc_q;
  logic [LCW-1:0]   s_q;
  logic             res_valid_q, res_last_q, res_err_q;
  logic [AddrW-1:0] res_addr_q;

  // RAM ports
  logic             a_we, m_we, l_we;
  logic [NW-1:0]    a_waddr, a_raddr, m_waddr, m_raddr;
  logic [AddrW-1:0] a_wdata, a_rdata;
  logic [MW-1:0]    m_wdata, m_rdata;
  logic [NW+LW-1:0] l_waddr, l_raddr;
  logic [NW-1:0]    l_wdata, l_rdata;

  logic             walking, add_ok, go;
  logic [LCW-1:0]   lc, tk;

  assign walking = (state_q == S_WRD) || (state_q == S_WLK) || (state_q == S_WTG);
  assign lc      = m_rdata[MW-1:LCW];
  assign tk      = m_rdata[LCW-1:0];
  assign add_ok  = (lc != LCW'(MaxLinks)) && (found_q || ncnt_q != CW'(MaxDepth));
  assign go      = (tk != LCW'(MaxLinks)) && (tk < lc);
  assign pop_o   = (state_q == S_IDLE) && head_valid_i;

  always_comb begin
    a_raddr = (state_q == S_NSCAN) ? j_q : n_q;
    m_raddr = walking ? n_q : cur_q;
    l_raddr = walking ? {n_q, tk[LW-1:0]} : {cur_q, s_q[LW-1:0]};
    a_we = 1'b0; a_waddr = '0; a_wdata = head_i.addr;
    m_we = 1'b0; m_waddr = cur_q; m_wdata = '0;
    l_we = 1'b0; l_waddr = {cur_q, lc[LW-1:0]};
    l_wdata = found_q ? tgt_q : ncnt_q[NW-1:0];
    case (state_q)
      S_IDLE: begin
        if (head_valid_i && head_i.kind == KIND_FIRST) begin
          a_we = 1'b1;
          m_we = 1'b1;
          m_waddr = '0;
        end
      end
      S_ADD: begin
        if (add_ok) begin
          l_we    = 1'b1;
          m_we    = 1'b1;
          m_wdata = {lc + 1'b1, LCW'(0)};
          if (!found_q) begin
            a_we    = 1'b1;
            a_waddr = ncnt_q[NW-1:0];
            a_wdata = addr_q;
          end
        end
      end
      S_NEWN: m_we = 1'b1;
      S_WLK: begin
        if (tk != LCW'(MaxLinks)) begin
          m_we    = 1'b1;
          m_waddr = n_q;
          m_wdata = {lc, tk + 1'b1};
        end
      end
      default: ;
    endcase
  end

  clsr_ram #(.Width(AddrW), .Depth(MaxDepth)) u_addr_ram (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(a_wdata),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );
  clsr_ram #(.Width(MW), .Depth(MaxDepth)) u_meta_ram (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(m_rdata)
  );
  clsr_ram #(.Width(NW), .Depth(LD)) u_link_ram (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .raddr_i(l_raddr), .rdata_o(l_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ovf_q       <= 1'b0;
      cur_q       <= '0;
      ncnt_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (head_valid_i) begin
            addr_q <= head_i.addr;
            last_q <= head_i.last;
            state_q <= S_FIN;
            if (head_i.kind == KIND_FIRST) begin
              ncnt_q <= CW'(1);
              cur_q  <= '0;
              ovf_q  <= 1'b0;
            end else if (head_i.kind == KIND_DEEP) begin
              ovf_q <= 1'b1;
            end else if (!ovf_q) begin
              j_q     <= '0;
              ph_q    <= 1'b0;
              state_q <= S_NSCAN;
            end
          end
        end
        S_NSCAN: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (a_rdata == addr_q) begin
              found_q <= 1'b1;
              tgt_q   <= j_q;
              state_q <= S_META;
            end else if ({1'b0, j_q} + 1'b1 == (NW+1)'(ncnt_q)) begin
              found_q <= 1'b0;
              state_q <= S_META;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        S_META: begin
          s_q  <= '0;
          ph_q <= 1'b0;
          state_q <= (found_q && lc != '0) ? S_LSCAN : S_ADD;
        end
        S_LSCAN: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (l_rdata == tgt_q) begin
              cur_q   <= tgt_q;
              state_q <= S_FIN;
            end else if (s_q + 1'b1 == lc) begin
              state_q <= S_ADD;
            end else begin
              s_q <= s_q + 1'b1;
            end
          end
        end
        S_ADD: begin
          if (!add_ok) begin
            ovf_q   <= 1'b1;
            state_q <= S_FIN;
          end else if (found_q) begin
            cur_q   <= tgt_q;
            state_q <= S_FIN;
          end else begin
            cur_q   <= ncnt_q[NW-1:0];
            ncnt_q  <= ncnt_q + 1'b1;
            state_q <= S_NEWN;
          end
        end
        S_NEWN: state_q <= S_FIN;
        S_FIN: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else if (ovf_q) begin
            state_q <= S_OVF;
          end else begin
            n_q     <= '0;
            rc_q    <= '0;
            state_q <= S_WRD;
          end
        end
        S_OVF: begin
          res_valid_q <= 1'b1;
          res_addr_q  <= '0;
          res_last_q  <= 1'b1;
          res_err_q   <= 1'b1;
          ovf_q       <= 1'b0;
          cur_q       <= '0;
          state_q     <= S_IDLE;
        end
        S_WRD: state_q <= S_WLK;
        S_WLK: begin
          if (go) begin
            state_q <= S_WTG;
          end else begin
            res_valid_q <= 1'b1;
            res_addr_q  <= a_rdata;
            res_last_q  <= 1'b1;
            res_err_q   <= 1'b0;
            cur_q       <= '0;
            state_q     <= S_IDLE;
          end
        end
        S_WTG: begin
          res_valid_q <= 1'b1;
          res_addr_q  <= a_rdata;
          res_err_q   <= 1'b0;
          if (rc_q == CW'(MaxDepth - 1)) begin
            res_last_q <= 1'b1;
            cur_q      <= '0;
            state_q    <= S_IDLE;
          end else begin
            res_last_q <= 1'b0;
            n_q        <= l_rdata;
            rc_q       <= rc_q + 1'b1;
            state_q    <= S_WRD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o   = res_valid_q;
  assign address_res_o = res_addr_q;
  assign last_res_o    = res_last_q;
  assign error_o       = res_err_q;

  ap_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_err_q |-> res_last_q && res_addr_q == '0)
    else $error("error beat must be a lone final beat with zero address");
  ap_ncnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ncnt_q <= CW'(MaxDepth)) else $error("node count out of range");
  ap_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ncnt_q != '0 && state_q == S_META |-> {1'b0, cur_q} < (NW+1)'(ncnt_q))
    else $error("current node not allocated");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for call_stack_loop_remover.
// It needs clsr_pkg and the block's RTL. It feeds call stacks, predicts the
// rebuilt stacks without loops, and checks every result beat.
module tb_top;
  import clsr_pkg::*;

  localparam int unsigned Depth    = 64;
  localparam int unsigned Links    = 8;
  localparam int unsigned DogLimit = 40000;

  typedef struct {
    logic [AddrW-1:0] addr;
    logic             last;
    int unsigned      gap;
    bit               hold;
  } frame_t;

  typedef struct {
    logic [AddrW-1:0] addr;
    logic             last;
    logic             err;
  } rebuilt_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic [AddrW-1:0] address_i = '0;
  logic             last_i = 1'b0;
  logic             res_valid_o;
  logic [AddrW-1:0] address_res_o;
  logic             last_res_o;
  logic             error_o;

  call_stack_loop_remover DUT (.*);

  always #10 clk_i = ~clk_i;

  // Predicted stack state, a copy of what the block keeps per stack
  logic [AddrW-1:0] node_addr [Depth];
  bit               node_used [Depth];
  int unsigned      link_dst  [Depth*Links];
  bit               link_used [Depth*Links];
  bit               link_done [Depth*Links];
  int unsigned      cur_node;
  int unsigned      frames_seen;
  bit               overflowed;

  frame_t      frame_q[$];    // frames waiting to be sent
  rebuilt_t    rebuilt_q[$];  // predicted result beats, oldest first
  int unsigned errors = 0;
  int unsigned dog = 0;
  bit          took = 1'b0;
  bit          holding = 1'b0;
  frame_t      cur;
  int unsigned wait_left = 0;
  int unsigned gap_mode = 0;

  // Step from the current node to a new address: reuse a matching link,
  // else allocate (or find) the node and record a link in the first free slot.
  task automatic step_to(input logic [AddrW-1:0] a);
    int unsigned base, free_slot, tgt, t;
    base = cur_node * Links;
    free_slot = Links;
    tgt = Depth;
    for (int s = 0; s < Links; s++) begin
      if (!link_used[base+s]) begin
        free_slot = s;
        break;
      end
      t = link_dst[base+s];
      if (node_used[t] && node_addr[t] == a) begin
        cur_node = t;
        return;
      end
    end
    for (int j = 0; j < Depth; j++) begin
      if (node_used[j] && node_addr[j] == a) begin
        tgt = j;
        break;
      end
    end
    if (tgt == Depth) begin
      for (int j = 0; j < Depth; j++) begin
        if (!node_used[j]) begin
          tgt = j;
          break;
        end
      end
      if (tgt == Depth || free_slot == Links) begin
        overflowed = 1'b1;
        return;
      end
      node_used[tgt] = 1'b1;
      node_addr[tgt] = a;
    end
    if (free_slot == Links) begin
      overflowed = 1'b1;
      return;
    end
    link_used[base+free_slot] = 1'b1;
    link_dst[base+free_slot] = tgt;
    cur_node = tgt;
  endtask

  // Walk from node 0 taking the first untaken slot and queue each address.
  task automatic walk_stack();
    int unsigned n, cnt, base;
    bit go;
    rebuilt_t r;
    n = 0;
    cnt = 0;
    go = 1'b1;
    while (go && cnt < Depth) begin
      base = n * Links;
      r.addr = node_addr[n];
      r.last = 1'b0;
      r.err = 1'b0;
      rebuilt_q.push_back(r);
      cnt++;
      go = 1'b0;
      for (int s = 0; s < Links; s++) begin
        if (!link_done[base+s]) begin
          link_done[base+s] = 1'b1;
          if (link_used[base+s]) begin
            n = link_dst[base+s];
            go = 1'b1;
          end
          break;
        end
      end
    end
    rebuilt_q[rebuilt_q.size()-1].last = 1'b1;
  endtask

  task automatic predict_frame(input logic [AddrW-1:0] a, input logic lst);
    rebuilt_t r;
    if (frames_seen == 0) begin
      // first beat of a stack: drop everything live, root the stack at node 0
      foreach (node_used[i]) node_used[i] = 1'b0;
      foreach (link_used[i]) begin
        link_used[i] = 1'b0;
        link_done[i] = 1'b0;
      end
      overflowed = 1'b0;
      node_used[0] = 1'b1;
      node_addr[0] = a;
      cur_node = 0;
      frames_seen = 1;
    end else if (!overflowed) begin
      if (frames_seen >= Depth) overflowed = 1'b1;
      else begin
        step_to(a);
        frames_seen++;
      end
    end
    if (lst) begin
      if (overflowed) begin
        r.addr = '0;
        r.last = 1'b1;
        r.err = 1'b1;
        rebuilt_q.push_back(r);
      end else walk_stack();
      frames_seen = 0;
      overflowed = 1'b0;
      cur_node = 0;
    end
  endtask

  // Monitor: check result beats first, then take the accepted input beat.
  always @(posedge clk_i) begin
    rebuilt_t e;
    if (rst_ni) begin
      took <= start_i && !busy_o;
      if (res_valid_o) begin
        if (rebuilt_q.size() == 0) begin
          $error("unexpected result beat address_res=%h", address_res_o);
          errors++;
        end else begin
          e = rebuilt_q.pop_front();
          if (address_res_o !== e.addr) begin
            $error("address_res expected %h actual %h", e.addr, address_res_o);
            errors++;
          end
          if (last_res_o !== e.last) begin
            $error("last_res expected %b actual %b", e.last, last_res_o);
            errors++;
          end
          if (error_o !== e.err) begin
            $error("error expected %b actual %b", e.err, error_o);
            errors++;
          end
        end
      end
      if (start_i && !busy_o) predict_frame(address_i, last_i);
      if (res_valid_o || (start_i && !busy_o)) dog <= 0;
      else if (dog >= DogLimit) begin
        $display("FAIL");
        $finish;
      end else dog <= dog + 1;
    end
  end

  // Driver: hold a beat until taken, then wait out the gap and send the next.
  always @(negedge clk_i) begin
    bit go;
    go = 1'b0;
    if (rst_ni) begin
      if (start_i && !took) go = 1'b1;
      else begin
        if (!holding && frame_q.size() > 0) begin
          cur = frame_q.pop_front();
          holding = 1'b1;
          wait_left = cur.gap;
        end
        if (holding) begin
          if (wait_left > 0) wait_left--;
          else if (!(cur.hold && rebuilt_q.size() > 0)) begin
            address_i <= cur.addr;
            last_i <= cur.last;
            go = 1'b1;
            holding = 1'b0;
          end
        end
      end
    end
    start_i <= go;
  end

  function automatic int unsigned draw_gap();
    if (gap_mode == 0) return 0;
    return $urandom_range(9, 0);
  endfunction

  task automatic add_frame(input logic [AddrW-1:0] a, input logic lst, input bit hold = 0);
    frame_t f;
    f.addr = a;
    f.last = lst;
    f.gap = draw_gap();
    f.hold = hold;
    frame_q.push_back(f);
  endtask

  function automatic logic [AddrW-1:0] rand_addr();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [AddrW-1:0] pool [6];
    logic [AddrW-1:0] hub;
    int unsigned len, sent;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: one-beat stack at zero, extremes with a loop, full link slots.
    gap_mode = 0;
    add_frame('0, 1'b1);
    add_frame('1, 1'b0);
    add_frame('0, 1'b0);
    add_frame('1, 1'b0);
    add_frame('0, 1'b1);
    gap_mode = 1;
    hub = rand_addr();
    for (int i = 0; i < Links + 1; i++) begin
      add_frame(hub, 1'b0);
      add_frame(rand_addr(), i == Links);
    end

    // Drain before random stacks: sender pauses until every result is back.
    sent = 0;
    while (sent < 10) begin
      gap_mode = $urandom_range(2, 0);
      foreach (pool[i]) pool[i] = rand_addr();
      pool[0] = ($urandom_range(3, 0) == 0) ? '0 : pool[0];
      pool[1] = ($urandom_range(3, 0) == 0) ? '1 : pool[1];
      len = $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(7, 0) == 0)
          add_frame(rand_addr(), i == len - 1, sent == 0 && i == 0);
        else
          add_frame(pool[$urandom_range(5, 0)], i == len - 1, sent == 0 && i == 0);
      end
      sent += len;
    end
    // Exact depth limit and one past it, with content that never repeats.
    gap_mode = 0;
    for (int i = 0; i < Depth; i++) add_frame(rand_addr(), i == Depth - 1);
    for (int i = 0; i <= Depth; i++) add_frame(rand_addr(), i == Depth);

    do @(posedge clk_i);
    while (frame_q.size() != 0 || holding || start_i || rebuilt_q.size() != 0);
    repeat (400) @(posedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/clsr_pkg.sv
hw/rtl/clsr_ram.sv
hw/rtl/clsr_front.sv
hw/rtl/clsr_back.sv
hw/rtl/call_stack_loop_remover.sv
sim/tb_top.sv
